FILE: rtl/ssfl_pkg.sv
// Package for the slab slot free list: command, status and register codes,
// payload structs and the state machine type. It depends on nothing else.

package ssfl_pkg;

  localparam int DEF_NUM_SLOTS  = 1024;
  localparam int DEF_SLAB_BYTES = 65536;

  localparam int IDX_W = 11;
  localparam int OFF_W = 16;
  localparam int SHF_W = 4;
  localparam int CMP_W = 17;
  localparam int LIM_W = 21;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_OBJECT_COUNT  = 2'd0;
  localparam logic [1:0] REG_STEP_SHIFT    = 2'd1;
  localparam logic [1:0] REG_OBJECTS_START = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [OFF_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] object_offset;
    logic [IDX_W-1:0] free_slots;
    logic             was_full;
    logic             now_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC
  } state_t;

endpackage

FILE: rtl/slab_slot_free_list_top.sv
// Slab slot free list: the whole block in one module, with the link memory.
// It depends on ssfl_pkg for codes, payload structs and the state type.
//
// Use: commands arrive on the in_ channel (valid/ready) as init, allocate or
// free; each gives exactly one result on the out_ channel. Init chains slots
// 0 to count-1 in order, one link memory entry per cycle, and loads its
// result with the last link write. Allocate reads the link of the head slot
// from the synchronous link memory and loads its result in S_ALLOC. Free,
// an allocate on an empty list and an unknown command load theirs in S_IDLE.
// One command is in work at a time; a new one is taken once the previous
// result has been loaded into the output register and that register is
// empty or being drained in the same cycle. Configuration is written over
// the APB-style port by the user only while the block is idle; the block
// does not enforce it. After reset the list has no free slots, registers
// hold their defaults and the link memory is empty until an init. A stalled
// receiver holds the result in the output register and blocks new commands.

module slab_slot_free_list_top #(
  parameter int NUM_SLOTS  = ssfl_pkg::DEF_NUM_SLOTS,
  parameter int SLAB_BYTES = ssfl_pkg::DEF_SLAB_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssfl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssfl_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ssfl_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [CMP_W-1:0] SLOTS_LIM = CMP_W'(NUM_SLOTS);
  localparam logic [LIM_W-1:0] BYTES_LIM = LIM_W'(SLAB_BYTES);

  logic [IDX_W-1:0] link_mem [NUM_SLOTS];

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] obj_count_r;
  logic [SHF_W-1:0] step_shift_r;
  logic [OFF_W-1:0] obj_start_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             hok_r, hok_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, res_nxt;
  logic             res_load;
  logic [IDX_W-1:0] rd_data_r;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [IDX_W-1:0] mem_wd;

  logic             in_fire, cfg_wr;
  logic [IDX_W-1:0] count;
  logic [CMP_W-1:0] head_ext, cnt_inc, idx_ext;
  logic             head_in_range, init_last;
  logic [OFF_W-1:0] alloc_off, diff, idx;
  logic             offs_ok, idx_ok;
  logic [IDX_W-1:0] free_inc, free_dec;

  assign pready    = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_OBJECT_COUNT:  prdata = 32'(obj_count_r);
      REG_STEP_SHIFT:    prdata = 32'(step_shift_r);
      REG_OBJECTS_START: prdata = 32'(obj_start_r);
      default:           prdata = 32'd0;
    endcase
  end

  assign count = (CMP_W'(obj_count_r) > SLOTS_LIM) ? IDX_W'(SLOTS_LIM) : obj_count_r;

  assign head_ext      = CMP_W'(head_r);
  assign head_in_range = head_ext < SLOTS_LIM;
  assign alloc_off     = obj_start_r + (OFF_W'(head_r) << step_shift_r);

  assign offs_ok  = (in_data.free_offset >= obj_start_r) &&
                    (LIM_W'(in_data.free_offset) < BYTES_LIM);
  assign diff     = in_data.free_offset - obj_start_r;
  assign idx      = diff >> step_shift_r;
  assign idx_ext  = CMP_W'(idx);
  assign idx_ok   = offs_ok && (idx < OFF_W'(count));
  assign free_inc = (free_r == {IDX_W{1'b1}}) ? free_r : free_r + 1'b1;
  assign free_dec = free_r - 1'b1;

  assign cnt_inc   = CMP_W'(cnt_r) + 1'b1;
  assign init_last = cnt_inc == CMP_W'(count);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.command == CMD_INIT && count != '0) begin
            state_nxt = S_INIT;
          end else if (in_data.command == CMD_ALLOC && free_r != '0) begin
            state_nxt = S_ALLOC;
          end
        end
      end
      S_INIT: begin
        if (init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_ALLOC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt = head_r;
    free_nxt = free_r;
    cnt_nxt  = cnt_r;
    off_nxt  = off_r;
    hok_nxt  = hok_r;
    res_load = 1'b0;
    res_nxt  = '0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    mem_re   = 1'b0;
    mem_ra   = head_ext[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.command)
            CMD_INIT: begin
              head_nxt = '0;
              cnt_nxt  = '0;
              free_nxt = count;
              if (count == '0) begin
                res_load = 1'b1;
                res_nxt.status = ST_DONE;
              end
            end
            CMD_ALLOC: begin
              res_nxt.free_slots = free_r;
              if (free_r == '0) begin
                res_load = 1'b1;
                res_nxt.status = ST_EMPTY;
              end else begin
                mem_re  = head_in_range;
                off_nxt = alloc_off;
                hok_nxt = head_in_range;
              end
            end
            CMD_FREE: begin
              res_load = 1'b1;
              if (!idx_ok) begin
                res_nxt.status     = ST_RANGE;
                res_nxt.free_slots = free_r;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = idx_ext[AW-1:0];
                mem_wd   = head_r;
                head_nxt = idx[IDX_W-1:0];
                free_nxt = free_inc;
                res_nxt.status     = ST_DONE;
                res_nxt.free_slots = free_inc;
                res_nxt.was_full   = free_r == '0;
                res_nxt.now_empty  = free_inc == count;
              end
            end
            default: begin
              res_load = 1'b1;
              res_nxt.status     = ST_DONE;
              res_nxt.free_slots = free_r;
            end
          endcase
        end
      end
      S_INIT: begin
        mem_we  = 1'b1;
        mem_wa  = cnt_r;
        mem_wd  = cnt_inc[IDX_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (init_last) begin
          res_load = 1'b1;
          res_nxt.status     = ST_DONE;
          res_nxt.free_slots = free_r;
        end
      end
      S_ALLOC: begin
        head_nxt = hok_r ? rd_data_r : '0;
        free_nxt = free_dec;
        res_load = 1'b1;
        res_nxt.status        = ST_DONE;
        res_nxt.object_offset = off_r;
        res_nxt.free_slots    = free_dec;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= link_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      obj_count_r  <= IDX_W'(1024);
      step_shift_r <= SHF_W'(6);
      obj_start_r  <= '0;
      head_r       <= '0;
      free_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_OBJECT_COUNT:  obj_count_r  <= pwdata[IDX_W-1:0];
          REG_STEP_SHIFT:    step_shift_r <= pwdata[SHF_W-1:0];
          REG_OBJECTS_START: obj_start_r  <= pwdata[OFF_W-1:0];
          default:           obj_start_r  <= obj_start_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    hok_r <= hok_nxt;
    if (res_load) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/ssfl_checker.sv
// Port-level checker for the slab slot free list, bound to the top level.
// It depends on ssfl_pkg for the status codes and the payload structs.

module ssfl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ssfl_pkg::out_item_t out_data
);
  import ssfl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed or vanished while stalled.");

  a_empty_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.object_offset == '0 && out_data.free_slots == '0)
    else $error("Failed allocate reported an offset or free slots.");

  a_range_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_RANGE |->
      !out_data.was_full && !out_data.now_empty && out_data.object_offset == '0)
    else $error("Rejected free reported flags or an offset.");

  a_was_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_full |-> out_data.free_slots == 11'd1)
    else $error("Free into a full slab did not leave one free slot.");

endmodule

bind slab_slot_free_list_top ssfl_checker u_ssfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
